### hdl/fid_pkg.sv
// Shared types and constants for the frame integrator / decimator.
// No dependencies; every other file references this package by scoped names.
package fid_pkg;

	localparam int MAX_ELEMENTS = 4096;
	localparam int POS_W        = 12;
	localparam int FE_W         = 13;
	localparam int SAMPLE_W     = 32;
	localparam int ACC_W        = 48;
	localparam int IV_W         = 17;
	localparam int DUR_W        = 16;
	localparam int MAG_W        = 17;
	localparam int VAL_W        = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 17;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = 2;
	localparam int QCNT_W       = 3;
	localparam int RC_W         = 5;   // recompute bit counter, holds DUR_W
	localparam int DIV_STAGES   = ACC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL = 2'd0,
		REG_DURATION = 2'd1,
		REG_ELEMENTS = 2'd2
	} cfg_reg_t;

	// One classified element, front to back.
	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [SAMPLE_W-1:0] sample;
		logic                first;
		logic                emit;
		logic                positive;
		logic [MAG_W-1:0]    mag;
		logic                last_el;
		logic                fin_frame;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             frame_end;
		logic             capture_done;
	} meta_t;

	typedef struct packed {
		logic [ACC_W-1:0] dividend;
		logic [MAG_W-1:0] divisor;
		meta_t            meta;
	} div_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		meta_t            meta;
	} res_t;

endpackage

### hdl/fid_front.sv
// Front end: config registers, element/frame counters and per-element classification.
// Depends on fid_pkg.
module fid_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fid_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [fid_pkg::SAMPLE_W-1:0]   sample,
	input  logic                          q_full,
	output logic                          push,
	output fid_pkg::item_t                push_item
);

	logic [fid_pkg::IV_W-1:0]  iv_q;
	logic [fid_pkg::DUR_W-1:0] dur_q;
	logic [fid_pkg::FE_W-1:0]  fe_q;
	logic [fid_pkg::POS_W-1:0] pos_q;
	logic [fid_pkg::DUR_W-1:0] fs_q;
	logic [fid_pkg::MAG_W-1:0] rem_q;   // frames_seen mod magnitude
	logic [fid_pkg::RC_W-1:0]  rc_q;

	logic [fid_pkg::FE_W-1:0]  fe_eff;
	logic [fid_pkg::MAG_W-1:0] mag_raw, mag;
	logic                      positive, emit, last_el, fin;
	logic [fid_pkg::MAG_W-1:0] cur;
	logic                      busy, cfg_wr, mag_wr;
	logic [3:0]                bi;
	logic [fid_pkg::MAG_W:0]   t;

	always_comb begin
		fe_eff = (fe_q > fid_pkg::FE_W'(fid_pkg::MAX_ELEMENTS)) ?
			fid_pkg::FE_W'(fid_pkg::MAX_ELEMENTS) : fe_q;
		if (iv_q == '0) begin
			positive = 1'b1;
			mag_raw  = {1'b0, dur_q};
		end else if (iv_q[fid_pkg::IV_W-1]) begin
			positive = 1'b0;
			mag_raw  = fid_pkg::MAG_W'(18'h20000 - {1'b0, iv_q});
		end else begin
			positive = 1'b1;
			mag_raw  = iv_q;
		end
		mag     = (mag_raw == '0) ? fid_pkg::MAG_W'(1) : mag_raw;
		cur     = {1'b0, fs_q} + fid_pkg::MAG_W'(1);
		emit    = ({1'b0, rem_q} + 18'd1) == {1'b0, mag};
		last_el = ({1'b0, pos_q} + fid_pkg::FE_W'(1)) >= fe_eff;
		fin     = cur >= {1'b0, dur_q};
		bi      = 4'(rc_q - fid_pkg::RC_W'(1));
		t       = {rem_q, fs_q[bi]};
	end

	assign busy         = rc_q != '0;
	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign mag_wr       = cfg_wr && (cfg_index == fid_pkg::REG_INTERVAL ||
		cfg_index == fid_pkg::REG_DURATION);
	// a register write takes the counters this cycle, so no word is taken with it
	assign sample_stall = q_full || busy || cfg_wr;
	assign push         = sample_valid && !sample_stall;

	always_comb begin
		push_item.pos       = pos_q;
		push_item.sample    = sample;
		push_item.first     = fs_q == '0;
		push_item.emit      = emit;
		push_item.positive  = positive;
		push_item.mag       = mag;
		push_item.last_el   = last_el;
		push_item.fin_frame = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q  <= fid_pkg::IV_W'(1);
			dur_q <= fid_pkg::DUR_W'(1);
			fe_q  <= fid_pkg::FE_W'(512);
			pos_q <= '0;
			fs_q  <= '0;
			rem_q <= '0;
			rc_q  <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					fid_pkg::REG_INTERVAL: iv_q  <= cfg_data[fid_pkg::IV_W-1:0];
					fid_pkg::REG_DURATION: dur_q <= cfg_data[fid_pkg::DUR_W-1:0];
					fid_pkg::REG_ELEMENTS: fe_q  <= cfg_data[fid_pkg::FE_W-1:0];
					default: ;
				endcase
			end
			if (mag_wr) begin
				// rebuild frames_seen mod magnitude, one bit per cycle
				rc_q  <= fid_pkg::RC_W'(fid_pkg::DUR_W);
				rem_q <= '0;
			end else if (busy) begin
				rc_q  <= rc_q - fid_pkg::RC_W'(1);
				rem_q <= (t >= {1'b0, mag}) ? fid_pkg::MAG_W'(t - {1'b0, mag}) :
					t[fid_pkg::MAG_W-1:0];
			end else if (push) begin
				if (last_el) begin
					pos_q <= '0;
					if (fin) begin
						fs_q  <= '0;
						rem_q <= '0;
					end else begin
						fs_q  <= cur[fid_pkg::DUR_W-1:0];
						rem_q <= emit ? '0 : rem_q + fid_pkg::MAG_W'(1);
					end
				end else begin
					pos_q <= pos_q + fid_pkg::POS_W'(1);
				end
			end
		end
	end

endmodule

### hdl/fid_queue.sv
// Short FIFO between the front end and the accumulate/divide back end.
// Depends on fid_pkg.
module fid_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fid_pkg::item_t     push_item,
	input  logic               pop,
	output fid_pkg::item_t     head,
	output fid_pkg::q_status_t status
);

	fid_pkg::item_t             mem_q [fid_pkg::QUEUE_DEPTH];
	logic [fid_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [fid_pkg::QCNT_W-1:0] cnt_q;

	assign status.full  = cnt_q == fid_pkg::QCNT_W'(fid_pkg::QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;
	assign head         = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + fid_pkg::QPTR_W'(1);
			if (pop)  rp_q <= rp_q + fid_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + fid_pkg::QCNT_W'(push) - fid_pkg::QCNT_W'(pop);
		end
	end

endmodule

### hdl/fid_accum.sv
// Accumulator read-modify-write: two stages around the per-element sum memory.
// Depends on fid_pkg.
module fid_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  fid_pkg::q_status_t q_status,
	input  fid_pkg::item_t     head,
	output logic               pop,
	output logic               div_valid,
	output fid_pkg::div_in_t   div_in
);

	logic [fid_pkg::ACC_W-1:0] acc_mem [fid_pkg::MAX_ELEMENTS];

	logic                      v_s1, v_s2, fwd_s2;
	fid_pkg::item_t            it_s1, it_s2;
	logic [fid_pkg::ACC_W-1:0] rd_s2, wd_q;
	logic [fid_pkg::ACC_W-1:0] base, acc, newval;

	assign pop = en && !q_status.empty;

	always_comb begin
		// a write from the previous element to the same entry is not yet in rd_s2
		base   = it_s2.first ? '0 : (fwd_s2 ? wd_q : rd_s2);
		acc    = base + fid_pkg::ACC_W'(it_s2.sample);
		newval = it_s2.emit ? '0 : acc;
		div_valid = v_s2 && (it_s2.emit || (it_s2.last_el && it_s2.fin_frame));
		if (!it_s2.emit) begin
			div_in.dividend = '0;
		end else if (it_s2.positive) begin
			div_in.dividend = acc;
		end else begin
			div_in.dividend = fid_pkg::ACC_W'(it_s2.sample);
		end
		div_in.divisor = (it_s2.emit && it_s2.positive) ? it_s2.mag : fid_pkg::MAG_W'(1);
		div_in.meta.pos          = it_s2.pos;
		div_in.meta.frame_end    = it_s2.emit && it_s2.last_el;
		div_in.meta.capture_done = it_s2.last_el && it_s2.fin_frame;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s2 <= acc_mem[it_s1.pos];
			if (v_s2) acc_mem[it_s2.pos] <= newval;
			wd_q   <= newval;
			it_s2  <= it_s1;
			fwd_s2 <= v_s2 && v_s1 && (it_s2.pos == it_s1.pos);
			if (pop) it_s1 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
		end
	end

endmodule

### hdl/fid_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with 32-bit saturation.
// Depends on fid_pkg.
module fid_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  fid_pkg::div_in_t din,
	output logic             out_valid,
	output fid_pkg::res_t    res
);

	localparam int N = fid_pkg::DIV_STAGES;

	logic                      v_s   [N+1];
	logic [fid_pkg::ACC_W-1:0] dq_s  [N+1];
	logic [fid_pkg::MAG_W-1:0] rem_s [N+1];
	logic [fid_pkg::MAG_W-1:0] d_s   [N+1];
	fid_pkg::meta_t            m_s   [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s[0]  <= din.dividend;
			rem_s[0] <= '0;
			d_s[0]   <= din.divisor;
			m_s[0]   <= din.meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [fid_pkg::MAG_W:0] t;
		logic                    ge;
		assign t  = {rem_s[g], dq_s[g][fid_pkg::ACC_W-1]};
		assign ge = t >= {1'b0, d_s[g]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? fid_pkg::MAG_W'(t - {1'b0, d_s[g]}) :
					t[fid_pkg::MAG_W-1:0];
				dq_s[g+1]  <= {dq_s[g][fid_pkg::ACC_W-2:0], ge};
				d_s[g+1]   <= d_s[g];
				m_s[g+1]   <= m_s[g];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (en) v_s[g+1] <= v_s[g];
		end
	end

	assign out_valid = v_s[N];
	assign res.value = (|dq_s[N][fid_pkg::ACC_W-1:fid_pkg::VAL_W]) ? '1 :
		dq_s[N][fid_pkg::VAL_W-1:0];
	assign res.meta  = m_s[N];

endmodule

### hdl/frame_integrator_decimator.sv
// Top level of the frame integrator / decimator: front end, queue, accumulator,
// divider pipeline and output register. Depends on fid_pkg and all fid_* modules.
//
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// sample    in         sample_valid / _stall  sample
// result    out        result_valid / _stall  value, element_index, frame_end, capture_done
//
// One element per clock sustained unless result_stall or a register write holds the input;
// each passes the queue, two accumulator stages, 48 divider stages, output register.
// The accumulator memory takes one read and one write each cycle the back end advances;
// back-to-back hits on one entry are forwarded.
// A write to interval_frames or duration_frames holds sample_stall while the frame phase
// is rebuilt. Reset loads the config defaults and clears counters and valid bits only.
// result_stall freezes the whole back end; the 4-deep queue keeps the input moving until full.
module frame_integrator_decimator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic [fid_pkg::SAMPLE_W-1:0]    sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [fid_pkg::VAL_W-1:0]       value,
	output logic [fid_pkg::POS_W-1:0]       element_index,
	output logic                           frame_end,
	output logic                           capture_done
);

	logic               q_push, q_pop, en;
	fid_pkg::item_t     push_item, head;
	fid_pkg::q_status_t q_status;
	logic               div_valid, dout_valid;
	fid_pkg::div_in_t   div_in;
	fid_pkg::res_t      dout;

	logic               result_valid_q;
	fid_pkg::res_t      res_q;

	// back end advances whenever the output register is free or being drained
	assign en = !result_valid_q || !result_stall;

	fid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_full       (q_status.full),
		.push         (q_push),
		.push_item    (push_item)
	);

	fid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head      (head),
		.status    (q_status)
	);

	fid_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.q_status  (q_status),
		.head      (head),
		.pop       (q_pop),
		.div_valid (div_valid),
		.div_in    (div_in)
	);

	fid_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.din       (div_in),
		.out_valid (dout_valid),
		.res       (dout)
	);

	always_ff @(posedge clk) begin
		if (en && dout_valid) res_q <= dout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (en) result_valid_q <= dout_valid;
	end

	assign result_valid  = result_valid_q;
	assign value         = res_q.value;
	assign element_index = res_q.meta.pos;
	assign frame_end     = res_q.meta.frame_end;
	assign capture_done  = res_q.meta.capture_done;

	// a capture end without an emitted frame carries a zero value
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && capture_done && !frame_end |-> value == '0)
		else $error("silent capture end with nonzero value");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty && en)
		else $error("queue pop while empty or frozen");

endmodule

### bench/frame_integrator_decimator_tb.sv
// Self-checking testbench for frame_integrator_decimator: drives sample words and
// register writes, predicts each result word and compares it field by field.
// Depends on fid_pkg and the frame_integrator_decimator RTL.
module frame_integrator_decimator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 80;     // longer than the pipe from accept to result
	localparam int IDLE_LIMIT   = 20000;  // cycles with no accepted word

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [fid_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fid_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           sample_valid = 1'b0;
	logic                           sample_stall;
	logic [fid_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic [fid_pkg::VAL_W-1:0]      value;
	logic [fid_pkg::POS_W-1:0]      element_index;
	logic                           frame_end;
	logic                           capture_done;

	frame_integrator_decimator dut (.*);

	always #1 clk = ~clk;

	// Predicted result word
	typedef struct {
		logic [fid_pkg::VAL_W-1:0] val;
		logic [fid_pkg::POS_W-1:0] idx;
		logic                      fend;
		logic                      cdone;
	} word_t;

	word_t expected_words[$];

	// Shadow of block state and registers
	logic [fid_pkg::ACC_W-1:0]  sums[fid_pkg::MAX_ELEMENTS];
	logic [fid_pkg::POS_W-1:0]  cur_pos;
	logic [fid_pkg::DUR_W-1:0]  frames_done;
	logic [fid_pkg::IV_W-1:0]   interval_reg;
	logic [fid_pkg::DUR_W-1:0]  duration_reg;
	logic [fid_pkg::FE_W-1:0]   elements_reg;

	int  errors = 0;
	int  idle_cycles = 0;
	bit  quiet = 1'b0;        // last part of the run: no idling
	bit  long_hold = 1'b0;    // receiver holds off for a long stretch

	// Predict the result (if any) of one accepted sample word.
	task automatic integrate_sample(input logic [fid_pkg::SAMPLE_W-1:0] s);
		int unsigned fe, pos, cur, dur, mag;
		bit pos_mode, emit, last_el, fin;
		logic [fid_pkg::ACC_W-1:0] acc;
		logic [63:0] avg;
		word_t w;
		fe = elements_reg;
		if (fe > fid_pkg::MAX_ELEMENTS) fe = fid_pkg::MAX_ELEMENTS;
		pos = cur_pos;
		cur = frames_done + 1;
		dur = duration_reg;
		if (interval_reg == 0) begin
			pos_mode = 1; mag = dur;
		end else if (interval_reg[fid_pkg::IV_W-1]) begin
			pos_mode = 0; mag = 32'h20000 - interval_reg;
		end else begin
			pos_mode = 1; mag = interval_reg;
		end
		if (mag == 0) mag = 1;
		emit = (cur % mag) == 0;
		last_el = (pos + 1) >= fe;
		fin = cur >= dur;
		acc = ((frames_done == 0) ? fid_pkg::ACC_W'(0) : sums[pos]) + fid_pkg::ACC_W'(s);
		if (emit) begin
			avg = pos_mode ? 64'(acc) / mag : 64'(s);
			if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
			sums[pos] = '0;
			w.val = avg[31:0]; w.idx = pos; w.fend = last_el; w.cdone = last_el && fin;
			expected_words.push_back(w);
		end else begin
			sums[pos] = acc;
			if (last_el && fin) begin
				w.val = '0; w.idx = pos; w.fend = 0; w.cdone = 1;
				expected_words.push_back(w);
			end
		end
		if (last_el) begin
			cur_pos = '0;
			frames_done = fin ? fid_pkg::DUR_W'(0) : fid_pkg::DUR_W'(cur);
		end else begin
			cur_pos = fid_pkg::POS_W'(pos + 1);
		end
	endtask

	// Send one sample word, with a random gap before it unless quiet.
	// Valid stays up for the next word; drain() drops it.
	task automatic send_sample(input logic [fid_pkg::SAMPLE_W-1:0] s);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		integrate_sample(s);
		@(negedge clk);
	endtask

	// Wait until every expected word has come, then let the pipe settle.
	task automatic drain();
		int guard;
		sample_valid <= 1'b0;
		guard = 0;
		while (expected_words.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register write, only while the block is idle; setup() drops valid.
	task automatic write_reg(input fid_pkg::cfg_reg_t r,
		input logic [fid_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			fid_pkg::REG_INTERVAL: interval_reg = d;
			fid_pkg::REG_DURATION: duration_reg = d[fid_pkg::DUR_W-1:0];
			fid_pkg::REG_ELEMENTS: elements_reg = d[fid_pkg::FE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic setup(input logic [fid_pkg::IV_W-1:0] iv, input int dur, input int fe);
		drain();
		write_reg(fid_pkg::REG_INTERVAL, iv);
		write_reg(fid_pkg::REG_DURATION, fid_pkg::CFG_DATA_W'(dur));
		write_reg(fid_pkg::REG_ELEMENTS, fid_pkg::CFG_DATA_W'(fe));
		cfg_valid <= 1'b0;
	endtask

	// Whole captures of random data; half full-range values, the rest all ones, zero or small values.
	task automatic run_captures(input int n_words);
		logic [fid_pkg::SAMPLE_W-1:0] s;
		for (int i = 0; i < n_words; i++) begin
			case ($urandom_range(0, 5))
				0: s = '1;
				1: s = '0;
				2: s = $urandom_range(0, 255);
				default: s = $urandom;
			endcase
			send_sample(s);
		end
	endtask

	// Reset-value registers: average over one frame of 512, one frame per capture.
	task automatic test_reset_defaults();
		for (int i = 0; i < 12; i++)
			send_sample(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
	endtask

	// Directed extremes: full scale sums, silent final frame, every-second-frame pass.
	task automatic test_directed();
		setup(fid_pkg::IV_W'(0), 3, 2);         // zero interval -> average over duration
		repeat (6) send_sample('1);
		setup(fid_pkg::IV_W'(4), 3, 2);         // silent final frame
		repeat (6) send_sample(32'h8000_0001);
		setup(fid_pkg::IV_W'(-2), 4, 3);        // pass every second frame
		for (int i = 0; i < 12; i++) send_sample(32'h1 << i);
		setup(fid_pkg::IV_W'(0), 0, 0);         // zero duration, zero frame length
		send_sample('1);
		send_sample(32'h5A5A_A5A5);
		setup(fid_pkg::IV_W'(65535), 1, 4096);  // largest interval, largest frame
		send_sample('1);
		setup(fid_pkg::IV_W'(-65535), 2, 1);    // negative interval of magnitude 65535
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		setup(fid_pkg::IV_W'(1), 65535, 1);     // longest capture, starts here only
		send_sample(32'h0000_FFFF);
	endtask

	// Random settings, complete captures for each setting.
	task automatic test_random();
		int dur, fe, ivm, words;
		logic [fid_pkg::IV_W-1:0] iv;
		for (int k = 0; k < 8; k++) begin
			dur = $urandom_range(1, 6);
			fe = $urandom_range(1, 8);
			ivm = $urandom_range(0, 7);
			iv = ($urandom_range(0, 2) == 0) ? fid_pkg::IV_W'(-ivm) : fid_pkg::IV_W'(ivm);
			setup(iv, dur, fe);
			words = dur * fe * $urandom_range(1, 2);
			if (words > 48) words = dur * fe;
			run_captures(words);
		end
	endtask

	// Long receiver hold while the sender keeps offering: input must stall.
	task automatic test_backpressure();
		setup(fid_pkg::IV_W'(-1), 2, 4);
		long_hold = 1'b1;
		run_captures(80);
		long_hold = 1'b0;
	endtask

	// No idling at all for the tail of the run.
	task automatic test_streaming();
		drain();
		quiet = 1'b1;
		setup(fid_pkg::IV_W'(2), 4, 5);
		run_captures(160);
	endtask

	// Receiver stall: random bursts, a long hold, none at the end.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				result_stall <= 1'b1;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
				result_stall <= 1'b0;
				wait (!long_hold);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		word_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word: value %h index %0d", value, element_index);
				errors++;
			end else begin
				w = expected_words.pop_front();
				if (value !== w.val) begin
					$error("value: expected %h, got %h", w.val, value); errors++;
				end
				if (element_index !== w.idx) begin
					$error("element_index: expected %0d, got %0d", w.idx, element_index);
					errors++;
				end
				if (frame_end !== w.fend) begin
					$error("frame_end: expected %b, got %b", w.fend, frame_end); errors++;
				end
				if (capture_done !== w.cdone) begin
					$error("capture_done: expected %b, got %b", w.cdone, capture_done);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles without any accepted word on any channel.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
		    || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < fid_pkg::MAX_ELEMENTS; i++) sums[i] = '0;
		cur_pos = '0;
		frames_done = '0;
		interval_reg = fid_pkg::IV_W'(1);
		duration_reg = fid_pkg::DUR_W'(1);
		elements_reg = fid_pkg::FE_W'(512);
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		// finish the 512-element frame so later settings start clean
		run_captures(500);
		test_directed();
		test_random();
		test_backpressure();
		test_streaming();
		drain();
		if (errors == 0 && expected_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### sim.f
hdl/fid_pkg.sv
hdl/fid_front.sv
hdl/fid_queue.sv
hdl/fid_accum.sv
hdl/fid_divider.sv
hdl/frame_integrator_decimator.sv
bench/frame_integrator_decimator_tb.sv
